### hdl/imsu_pkg.sv
package imsu_pkg;

  // field widths of the request and result items
  localparam int unsigned CoordW = 6;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned RndW   = 7;

  // flip threshold registers: five 7-bit fields, field k for k aligned neighbours
  localparam int unsigned ThrW    = 7;
  localparam int unsigned NumThr  = 5;
  localparam int unsigned CfgW    = NumThr * ThrW;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgThrUp   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThrDown = 2'd1;

  // request codes, any other code acts as a read
  localparam logic [ReqW-1:0] ReqUpdate = 2'd0;
  localparam logic [ReqW-1:0] ReqWrite  = 2'd1;

  typedef logic [NumThr-1:0][ThrW-1:0] thr_set_t;

  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [RndW-1:0]   random_value;
    logic              spin_in;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] row_out;
    logic [CoordW-1:0] col_out;
    logic              spin_out;
    logic              flipped;
  } out_item_t;

endpackage

### hdl/imsu_ram.sv
module imsu_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/ising_metropolis_site_update.sv
// Site update engine for a SIDE x SIDE lattice of one-bit spins with periodic wraparound.
// Request channel (in_valid_i / in_ready_o / in_item_i): each item writes a spin, reads
// a spin, or runs one Metropolis update at (row, col); row and col are reduced modulo
// SIDE first. Result channel (out_valid_o / out_ready_i / out_item_o): exactly one item
// per request with the reduced site, its spin afterwards and a flip flag.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): always
// ready; index 0 loads the up-spin thresholds, index 1 the down-spin thresholds, other
// indexes are ignored. Write it only while no request is in flight.
// One request is handled at a time. All lattice accesses go through a single RAM port
// pair, and request accesses through one shared row*SIDE+col address unit, so an update
// reads the site and its four neighbours one per cycle. A write goes through S_WRITE, a
// read through S_SCAN, an update through S_SCAN and S_DEC, then each through S_RES.
// After reset the lattice is cleared one site per cycle, all SIDE*SIDE sites (4096 at
// the default size), with in_ready_o low; configuration writes are taken meanwhile.
// The result sits in an output register. While the receiver stalls, the next request is
// still accepted and worked on, and waits at its end until the output register frees.
module ising_metropolis_site_update #(
  parameter int unsigned SIDE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  imsu_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output imsu_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [imsu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [imsu_pkg::CfgW-1:0]    cfg_data_i
);

  import imsu_pkg::*;

  localparam int unsigned AW    = $clog2(SIDE);
  localparam int unsigned Depth = SIDE * SIDE;
  localparam int unsigned DW    = $clog2(Depth);
  localparam int unsigned NumCoord = 1 << CoordW;

  localparam logic [AW-1:0] MaxCoord = AW'(SIDE - 1);
  localparam logic [DW-1:0] LastAddr = DW'(Depth - 1);
  localparam logic [DW-1:0] SideW    = DW'(SIDE);

  // scan steps: address issued at step k, its data returns at step k+1
  localparam int unsigned StepW = 3;
  localparam logic [StepW-1:0] StepSite     = 3'd0;
  localparam logic [StepW-1:0] StepRowUp    = 3'd1;
  localparam logic [StepW-1:0] StepRowDown  = 3'd2;
  localparam logic [StepW-1:0] StepColUp    = 3'd3;
  localparam logic [StepW-1:0] StepColDown  = 3'd4;
  localparam logic [StepW-1:0] StepLast     = 3'd5;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_WRITE = 6'b001000,
    S_DEC   = 6'b010000,
    S_RES   = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [DW-1:0]   clr_q, clr_d;
  logic [StepW-1:0] step_q, step_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;
  thr_set_t        thr_up_q, thr_dn_q;

  logic [AW-1:0]   r_q, r_d, c_q, c_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            spin_q, spin_d;
  logic            upd_q, upd_d;
  logic            me_q, me_d;
  logic [2:0]      aligned_q, aligned_d;
  logic            res_spin_q, res_spin_d;
  logic            res_flip_q, res_flip_d;

  logic [AW-1:0]   red_tbl [NumCoord];
  logic [AW-1:0]   r_up, r_dn, c_up, c_dn, sel_r, sel_c;
  logic [DW-1:0]   addr, ram_waddr;
  logic            ram_we, ram_wdata, ram_rdata;
  thr_set_t        thr_set;
  logic [ThrW-1:0] thr;
  logic            flip, out_free;

  // coordinate reduction modulo SIDE as a constant table
  for (genvar g = 0; g < NumCoord; g++) begin : g_red
    localparam int unsigned Red = g % SIDE;
    assign red_tbl[g] = AW'(Red);
  end

  // wrapped neighbour coordinates
  assign r_up = (r_q == MaxCoord) ? '0 : r_q + AW'(1);
  assign r_dn = (r_q == '0) ? MaxCoord : r_q - AW'(1);
  assign c_up = (c_q == MaxCoord) ? '0 : c_q + AW'(1);
  assign c_dn = (c_q == '0) ? MaxCoord : c_q - AW'(1);

  // shared address unit: site or neighbour chosen by the scan step
  always_comb begin
    sel_r = r_q;
    sel_c = c_q;
    if (state_q == S_SCAN) begin
      unique case (step_q)
        StepRowUp:   sel_r = r_up;
        StepRowDown: sel_r = r_dn;
        StepColUp:   sel_c = c_up;
        StepColDown: sel_c = c_dn;
        default: ;
      endcase
    end
  end

  assign addr      = DW'(sel_r) * SideW + DW'(sel_c);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : addr;

  imsu_ram #(
    .Width(1),
    .Depth(Depth)
  ) u_lattice (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr),
    .rdata_o(ram_rdata)
  );

  // threshold pick and flip decision
  assign thr_set  = me_q ? thr_up_q : thr_dn_q;
  assign thr      = thr_set[aligned_q];
  assign flip     = rnd_q < thr;
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    r_d         = r_q;
    c_d         = c_q;
    rnd_d       = rnd_q;
    spin_d      = spin_q;
    upd_d       = upd_q;
    me_d        = me_q;
    aligned_d   = aligned_q;
    res_spin_d  = res_spin_q;
    res_flip_d  = res_flip_q;
    ram_we      = 1'b0;
    ram_wdata   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + DW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          r_d       = red_tbl[in_item_i.row];
          c_d       = red_tbl[in_item_i.col];
          rnd_d     = in_item_i.random_value;
          spin_d    = in_item_i.spin_in;
          upd_d     = (in_item_i.req_type == ReqUpdate);
          step_d    = StepSite;
          aligned_d = '0;
          state_d   = (in_item_i.req_type == ReqWrite) ? S_WRITE : S_SCAN;
        end
      end
      S_SCAN: begin
        step_d = step_q + StepW'(1);
        if (step_q == StepRowUp) begin
          // site spin returns
          me_d      = ram_rdata;
          aligned_d = '0;
          if (!upd_q) begin
            res_spin_d = ram_rdata;
            res_flip_d = 1'b0;
            state_d    = S_RES;
          end
        end else if (step_q > StepRowUp) begin
          // one neighbour returns per cycle
          aligned_d = aligned_q + {2'b00, (ram_rdata == me_q)};
          if (step_q == StepLast) begin
            state_d = S_DEC;
          end
        end
      end
      S_WRITE: begin
        ram_we     = 1'b1;
        ram_wdata  = spin_q;
        res_spin_d = spin_q;
        res_flip_d = 1'b0;
        state_d    = S_RES;
      end
      S_DEC: begin
        ram_we     = flip;
        ram_wdata  = !me_q;
        res_spin_d = me_q ^ flip;
        res_flip_d = flip;
        state_d    = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_item_d.row_out  = CoordW'(r_q);
          out_item_d.col_out  = CoordW'(c_q);
          out_item_d.spin_out = res_spin_q;
          out_item_d.flipped  = res_flip_q;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      thr_up_q    <= '0;
      thr_dn_q    <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_index_i == CfgThrUp) begin
        thr_up_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CfgThrDown) begin
        thr_dn_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    r_q        <= r_d;
    c_q        <= c_d;
    rnd_q      <= rnd_d;
    spin_q     <= spin_d;
    upd_q      <= upd_d;
    me_q       <= me_d;
    aligned_q  <= aligned_d;
    res_spin_q <= res_spin_d;
    res_flip_q <= res_flip_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  // checks on the sequencer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_result_from_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RES))
    else $error("result raised outside the result state");

  a_aligned_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC) |-> (aligned_q <= 3'd4))
    else $error("aligned neighbour count out of range");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (step_q <= StepLast))
    else $error("scan step out of range");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && clr_q != LastAddr) |=> (state_q == S_CLEAR))
    else $error("clearing pass left early");

endmodule
